// File: sv/block_cyclic_tile_mapper_top_assert.svh
// Assertion macros for the block-cyclic tile mapper
`ifndef BLOCK_CYCLIC_TILE_MAPPER_TOP_ASSERT_SVH
`define BLOCK_CYCLIC_TILE_MAPPER_TOP_ASSERT_SVH

// Same-cycle implication
`define BCTM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BCTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bctm_pkg.sv
// Shared types and constants for the block-cyclic tile mapper
`timescale 1ns / 1ps
package bctm_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_OFFSETS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SHAPE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_DEPTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_START      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_GRID         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ROW_TILES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_TILES    = 3'd6;

    // request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_queue_status;

endpackage

// File: sv/bctm_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes
`timescale 1ns / 1ps
module bctm_div #(
    parameter int LANES = 1,
    parameter int NW    = 32,
    parameter int DW    = 16,
    parameter int PW    = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_v,
    input  logic [LANES-1:0][NW-1:0]   i_num,
    input  logic [LANES-1:0][DW-1:0]   i_den,
    input  logic [PW-1:0]              i_pay,
    output logic                       o_v,
    output logic [LANES-1:0][NW-1:0]   o_quo,
    output logic [LANES-1:0][DW-1:0]   o_rem,
    output logic [PW-1:0]              o_pay
);

    logic [LANES-1:0][NW-1:0] x_q   [0:NW];
    logic [LANES-1:0][DW-1:0] rem_q [0:NW];
    logic                     v_q   [0:NW];
    logic [PW-1:0]            pay_q [0:NW];

    assign x_q[0]   = i_num;
    assign rem_q[0] = '0;
    assign v_q[0]   = i_v;
    assign pay_q[0] = i_pay;

    for (genvar s = 1; s <= NW; s++) begin : g_st
        logic [LANES-1:0][DW:0]   t;
        logic [LANES-1:0][DW:0]   diff;
        logic [LANES-1:0]         ge;
        logic [LANES-1:0][NW-1:0] n_x;
        logic [LANES-1:0][DW-1:0] n_rem;
        logic                     r_v;
        logic [LANES-1:0][NW-1:0] r_x;
        logic [LANES-1:0][DW-1:0] r_rem;
        logic [PW-1:0]            r_pay;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                t[l]     = {rem_q[s-1][l], x_q[s-1][l][NW-1]};
                ge[l]    = (t[l] >= {1'b0, i_den[l]});
                diff[l]  = t[l] - {1'b0, i_den[l]};
                n_rem[l] = ge[l] ? diff[l][DW-1:0] : t[l][DW-1:0];
                n_x[l]   = {x_q[s-1][l][NW-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= v_q[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x   <= n_x;
                r_rem <= n_rem;
                r_pay <= pay_q[s-1];
            end
        end

        assign x_q[s]   = r_x;
        assign rem_q[s] = r_rem;
        assign v_q[s]   = r_v;
        assign pay_q[s] = r_pay;
    end

    assign o_v   = v_q[NW];
    assign o_quo = x_q[NW];
    assign o_rem = rem_q[NW];
    assign o_pay = pay_q[NW];

endmodule

// File: sv/bctm_front.sv
// Front end: accepts requests, forms global coordinates, queues them
`timescale 1ns / 1ps
module bctm_front #(
    parameter int CB = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [CB-1:0]               i_tile_row,
    input  logic [CB-1:0]               i_tile_col,
    input  logic [2*CB-1:0]             i_tile_key,
    input  logic [CB-1:0]               i_row_off,
    input  logic [CB-1:0]               i_col_off,
    input  logic                        i_pop,
    output logic [4*CB+2:0]             o_entry,
    output bctm_pkg::t_queue_status     o_status
);
    import bctm_pkg::*;

    localparam int EW = 4 * CB + 3;

    logic [EW-1:0]     r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              full;
    logic              push;
    logic [CB:0]       gmc;
    logic [CB:0]       gnc;

    assign full = (r_cnt == QCNT_W'(QDEPTH));
    assign push = i_in_valid && !full;
    assign gmc  = {1'b0, i_tile_row} + {1'b0, i_row_off};
    assign gnc  = {1'b0, i_tile_col} + {1'b0, i_col_off};

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= {i_cmd, i_tile_key, gmc, gnc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_in_stall     = full;
    assign o_entry        = r_mem[r_rp];
    assign o_status.full  = full;
    assign o_status.empty = (r_cnt == '0);
    assign o_status.count = r_cnt;

endmodule

// File: sv/bctm_back.sv
// Back end: divider chain and products giving owner, local slot and key
`timescale 1ns / 1ps
module bctm_back #(
    parameter int CB = 16,
    parameter int GB = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4*CB+2:0]    i_entry,
    input  logic               i_entry_valid,
    output logic               o_pop,
    input  logic [GB-1:0]      i_rows,
    input  logic [GB-1:0]      i_cols,
    input  logic [GB-1:0]      i_kr,
    input  logic [GB-1:0]      i_kc,
    input  logic [GB-1:0]      i_ip,
    input  logic [GB-1:0]      i_jq,
    input  logic [GB-1:0]      i_p,
    input  logic [GB-1:0]      i_q,
    input  logic [CB-1:0]      i_lrt,
    input  logic [CB-1:0]      i_lmt,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [2*GB-1:0]    o_owner_rank,
    output logic [2*GB-1:0]    o_vp_index,
    output logic [CB-1:0]      o_local_row,
    output logic [CB-1:0]      o_local_col,
    output logic [2*CB-1:0]    o_local_position,
    output logic [2*CB-1:0]    o_global_key
);

    localparam int KW  = 2 * CB;
    localparam int EW  = 4 * CB + 3;
    localparam int P1W = 2 * CB + 3;
    localparam int P3W = KW + 2 * GB;
    localparam int P4W = KW + CB + 1 + KW;

    logic en;

    // whole back pipeline advances whenever the output register can take data
    assign en    = !o_out_valid || !i_out_stall;
    assign o_pop = en && i_entry_valid;

    // ---- key split: key / column_tiles
    logic                     d1_v;
    logic [0:0][KW-1:0]       d1_quo;
    logic [0:0][CB-1:0]       d1_rem;
    logic [P1W-1:0]           d1_pay;

    bctm_div #(.LANES(1), .NW(KW), .DW(CB), .PW(P1W)) u_div_key (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_v    (i_entry_valid),
        .i_num  (i_entry[EW-2 -: KW]),
        .i_den  (i_lmt),
        .i_pay  ({i_entry[EW-1], i_entry[2*CB+1:0]}),
        .o_v    (d1_v),
        .o_quo  (d1_quo),
        .o_rem  (d1_rem),
        .o_pay  (d1_pay)
    );

    logic            s1_cmd;
    logic [CB:0]     s1_gm;
    logic [KW-1:0]   s1_gn;
    logic [KW-1:0]   s1_hi_full;
    logic            r_s1_v;
    logic [CB:0]     r_s1_gm;
    logic [KW-1:0]   r_s1_gn;
    logic [KW-1:0]   r_s1_plo;
    logic [CB-1:0]   r_s1_phi;
    logic [KW-1:0]   s1_gk;

    assign s1_cmd     = d1_pay[P1W-1];
    assign s1_gm      = s1_cmd ? {1'b0, d1_rem[0]} : d1_pay[2*CB+1:CB+1];
    assign s1_gn      = s1_cmd ? d1_quo[0] : KW'(d1_pay[CB:0]);
    assign s1_hi_full = s1_gn[KW-1:CB] * i_lmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_gm  <= s1_gm;
            r_s1_gn  <= s1_gn;
            r_s1_plo <= s1_gn[CB-1:0] * i_lmt;
            r_s1_phi <= s1_hi_full[CB-1:0];
        end
    end

    assign s1_gk = r_s1_plo + {r_s1_phi, CB'(0)} + KW'(r_s1_gm);

    // ---- g / k on both axes
    logic                     d2_v;
    logic [1:0][KW-1:0]       d2_quo;
    logic [1:0][GB-1:0]       d2_rem;
    logic [KW-1:0]            d2_pay;

    bctm_div #(.LANES(2), .NW(KW), .DW(GB), .PW(KW)) u_div_cyc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_v    (r_s1_v),
        .i_num  ({r_s1_gn, KW'(r_s1_gm)}),
        .i_den  ({i_kc, i_kr}),
        .i_pay  (s1_gk),
        .o_v    (d2_v),
        .o_quo  (d2_quo),
        .o_rem  (d2_rem),
        .o_pay  (d2_pay)
    );

    // ---- (g / k) split by grid dimension
    logic                     d3_v;
    logic [1:0][KW-1:0]       d3_quo;
    logic [1:0][GB-1:0]       d3_rem;
    logic [P3W-1:0]           d3_pay;

    bctm_div #(.LANES(2), .NW(KW), .DW(GB), .PW(P3W)) u_div_grid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_v    (d2_v),
        .i_num  (d2_quo),
        .i_den  ({i_cols, i_rows}),
        .i_pay  ({d2_pay, d2_rem[0], d2_rem[1]}),
        .o_v    (d3_v),
        .o_quo  (d3_quo),
        .o_rem  (d3_rem),
        .o_pay  (d3_pay)
    );

    logic [CB+GB:0]    s3_mr_full;
    logic [CB+GB-1:0]  s3_mcl_full;
    logic [CB+GB-1:0]  s3_mch_full;
    logic              r_s3_v;
    logic [CB:0]       r_s3_mr;
    logic [KW-1:0]     r_s3_mcl;
    logic [CB-1:0]     r_s3_mch;
    logic [GB-1:0]     r_s3_br;
    logic [GB-1:0]     r_s3_bc;
    logic [GB:0]       r_s3_tr;
    logic [GB:0]       r_s3_tc;
    logic [KW-1:0]     r_s3_gk;
    logic [CB:0]       s3_lr;
    logic [KW-1:0]     s3_lc;

    // local row quotient is bounded by the row, so the low bits are exact
    assign s3_mr_full  = d3_quo[0][CB:0] * i_kr;
    assign s3_mcl_full = d3_quo[1][CB-1:0] * i_kc;
    assign s3_mch_full = d3_quo[1][KW-1:CB] * i_kc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_mr  <= s3_mr_full[CB:0];
            r_s3_mcl <= KW'(s3_mcl_full);
            r_s3_mch <= s3_mch_full[CB-1:0];
            r_s3_br  <= d3_pay[2*GB-1:GB];
            r_s3_bc  <= d3_pay[GB-1:0];
            r_s3_tr  <= {1'b0, d3_rem[0]} + {1'b0, i_ip};
            r_s3_tc  <= {1'b0, d3_rem[1]} + {1'b0, i_jq};
            r_s3_gk  <= d3_pay[P3W-1:2*GB];
        end
    end

    assign s3_lr = r_s3_mr + (CB+1)'(r_s3_br);
    assign s3_lc = r_s3_mcl + {r_s3_mch, CB'(0)} + KW'(r_s3_bc);

    // ---- grid coordinates with start and the vp residues
    logic                     d4_v;
    logic [3:0][GB-1:0]       d4_rem;
    logic [P4W-1:0]           d4_pay;

    bctm_div #(.LANES(4), .NW(KW), .DW(GB), .PW(P4W)) u_div_coord (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_v    (r_s3_v),
        .i_num  ({s3_lc, KW'(s3_lr), KW'(r_s3_tc), KW'(r_s3_tr)}),
        .i_den  ({i_q, i_p, i_cols, i_rows}),
        .i_pay  ({r_s3_gk, s3_lr, s3_lc}),
        .o_v    (d4_v),
        .o_quo  (),
        .o_rem  (d4_rem),
        .o_pay  (d4_pay)
    );

    logic [CB:0]       s5_lr;
    logic [KW-1:0]     s5_lc;
    logic [KW-1:0]     s5_hi_full;
    logic              r_s5_v;
    logic [2*GB-1:0]   r_s5_own;
    logic [GB-1:0]     r_s5_cr;
    logic [2*GB-1:0]   r_s5_vp;
    logic [GB-1:0]     r_s5_lrp;
    logic [KW-1:0]     r_s5_plo;
    logic [CB-1:0]     r_s5_phi;
    logic [CB:0]       r_s5_lr;
    logic [CB-1:0]     r_s5_lc;
    logic [KW-1:0]     r_s5_gk;

    assign s5_lc      = d4_pay[KW-1:0];
    assign s5_lr      = d4_pay[KW+CB:KW];
    assign s5_hi_full = s5_lc[KW-1:CB] * i_lrt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s5_v <= d4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_own <= d4_rem[0] * i_cols;
            r_s5_cr  <= d4_rem[1];
            r_s5_vp  <= d4_rem[3] * i_p;
            r_s5_lrp <= d4_rem[2];
            r_s5_plo <= s5_lc[CB-1:0] * i_lrt;
            r_s5_phi <= s5_hi_full[CB-1:0];
            r_s5_lr  <= s5_lr;
            r_s5_lc  <= s5_lc[CB-1:0];
            r_s5_gk  <= d4_pay[P4W-1:KW+CB+1];
        end
    end

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_owner_rank     <= r_s5_own + (2*GB)'(r_s5_cr);
            o_vp_index       <= r_s5_vp + (2*GB)'(r_s5_lrp);
            o_local_row      <= r_s5_lr[CB-1:0];
            o_local_col      <= r_s5_lc;
            o_local_position <= r_s5_plo + {r_s5_phi, CB'(0)} + KW'(r_s5_lr);
            o_global_key     <= r_s5_gk;
        end
    end

endmodule

// File: sv/block_cyclic_tile_mapper_top.sv
// Top level of the block-cyclic tile mapper: config registers, front, back
// Throughput: one request per cycle while the output is not stalled,
// set by the fully pipelined bit-per-stage dividers.
// A four-entry queue parts the request side from the divider pipeline.
// Reset (synchronous, active low) empties queue and pipeline; registers take defaults.
`timescale 1ns / 1ps
`include "block_cyclic_tile_mapper_top_assert.svh"
module block_cyclic_tile_mapper_top #(
    parameter int COORD_BITS = 16,
    parameter int GRID_BITS  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bctm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [((2*COORD_BITS > 2*GRID_BITS) ? 2*COORD_BITS : 2*GRID_BITS)-1:0]
                                          i_cfg_data,
    // requests
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [COORD_BITS-1:0]         i_tile_row,
    input  logic [COORD_BITS-1:0]         i_tile_col,
    input  logic [2*COORD_BITS-1:0]       i_tile_key,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2*GRID_BITS-1:0]        o_owner_rank,
    output logic [2*GRID_BITS-1:0]        o_vp_index,
    output logic [COORD_BITS-1:0]         o_local_row,
    output logic [COORD_BITS-1:0]         o_local_col,
    output logic [2*COORD_BITS-1:0]       o_local_position,
    output logic [2*COORD_BITS-1:0]       o_global_key
);
    import bctm_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int GB    = GRID_BITS;
    localparam int INF_W = $clog2(8 * CB + QDEPTH + 8) + 1;

    // configuration registers, always ready
    logic [2*CB-1:0] r_tile_offsets;
    logic [2*GB-1:0] r_grid_shape;
    logic [2*GB-1:0] r_cycle_depth;
    logic [2*GB-1:0] r_grid_start;
    logic [2*GB-1:0] r_vp_grid;
    logic [CB-1:0]   r_local_row_tiles;
    logic [CB-1:0]   r_column_tiles;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_offsets    <= '0;
            r_grid_shape      <= {GB'(1), GB'(1)};
            r_cycle_depth     <= {GB'(1), GB'(1)};
            r_grid_start      <= '0;
            r_vp_grid         <= {GB'(1), GB'(1)};
            r_local_row_tiles <= '0;
            r_column_tiles    <= CB'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TILE_OFFSETS:    r_tile_offsets    <= i_cfg_data[2*CB-1:0];
                CFG_GRID_SHAPE:      r_grid_shape      <= i_cfg_data[2*GB-1:0];
                CFG_CYCLE_DEPTH:     r_cycle_depth     <= i_cfg_data[2*GB-1:0];
                CFG_GRID_START:      r_grid_start      <= i_cfg_data[2*GB-1:0];
                CFG_VP_GRID:         r_vp_grid         <= i_cfg_data[2*GB-1:0];
                CFG_LOCAL_ROW_TILES: r_local_row_tiles <= i_cfg_data[CB-1:0];
                CFG_COLUMN_TILES:    r_column_tiles    <= i_cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    // divisors: a zero field counts as one
    logic [GB-1:0] rows, cols, kr, kc, p, q;
    logic [CB-1:0] lmt;

    assign rows = (r_grid_shape[GB-1:0] == '0)       ? GB'(1) : r_grid_shape[GB-1:0];
    assign cols = (r_grid_shape[2*GB-1:GB] == '0)    ? GB'(1) : r_grid_shape[2*GB-1:GB];
    assign kr   = (r_cycle_depth[GB-1:0] == '0)      ? GB'(1) : r_cycle_depth[GB-1:0];
    assign kc   = (r_cycle_depth[2*GB-1:GB] == '0)   ? GB'(1) : r_cycle_depth[2*GB-1:GB];
    assign p    = (r_vp_grid[GB-1:0] == '0)          ? GB'(1) : r_vp_grid[GB-1:0];
    assign q    = (r_vp_grid[2*GB-1:GB] == '0)       ? GB'(1) : r_vp_grid[2*GB-1:GB];
    assign lmt  = (r_column_tiles == '0)             ? CB'(1) : r_column_tiles;

    // front: transfer in, global coordinates, queue
    logic [4*CB+2:0] w_entry;
    t_queue_status   w_qstat;
    logic            w_pop;

    bctm_front #(.CB(CB)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_cmd     (i_cmd),
        .i_tile_row(i_tile_row),
        .i_tile_col(i_tile_col),
        .i_tile_key(i_tile_key),
        .i_row_off (r_tile_offsets[CB-1:0]),
        .i_col_off (r_tile_offsets[2*CB-1:CB]),
        .i_pop     (w_pop),
        .o_entry   (w_entry),
        .o_status  (w_qstat)
    );

    // back: key split, k-cyclic mapping, products, output register
    bctm_back #(.CB(CB), .GB(GB)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry         (w_entry),
        .i_entry_valid   (!w_qstat.empty),
        .o_pop           (w_pop),
        .i_rows          (rows),
        .i_cols          (cols),
        .i_kr            (kr),
        .i_kc            (kc),
        .i_ip            (r_grid_start[GB-1:0]),
        .i_jq            (r_grid_start[2*GB-1:GB]),
        .i_p             (p),
        .i_q             (q),
        .i_lrt           (r_local_row_tiles),
        .i_lmt           (lmt),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_owner_rank    (o_owner_rank),
        .o_vp_index      (o_vp_index),
        .o_local_row     (o_local_row),
        .o_local_col     (o_local_col),
        .o_local_position(o_local_position),
        .o_global_key    (o_global_key)
    );

    // requests in flight, for checking only
    logic [INF_W-1:0] r_inflight;
    logic             acc_in;
    logic             acc_out;

    assign acc_in  = i_in_valid && !o_in_stall;
    assign acc_out = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            case ({acc_in, acc_out})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    `BCTM_ASSERT_NOW(a_no_phantom, i_clk, i_rst_n,
        r_inflight == '0, !o_out_valid, "result with nothing in flight")
    `BCTM_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n,
        1'b1, w_qstat.count <= QCNT_W'(QDEPTH), "queue overfilled")
    `BCTM_ASSERT_NEXT(a_held_queue, i_clk, i_rst_n,
        acc_in && w_qstat.empty, !w_qstat.empty, "transfer lost from queue")

endmodule
